[rtl/qsed_pkg.sv]
// ----------------------------------------------------------------------------
// qsed_pkg
// Shared types, character codes and the escape table for the decoder.
// ----------------------------------------------------------------------------
package qsed_pkg;

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] BSLASH_CH = 8'h5C;

  // scanner phase, one-hot
  typedef enum logic [2:0] {
    PH_OPEN = 3'b001,
    PH_BODY = 3'b010,
    PH_ESC  = 3'b100
  } phase_t;

  // first scan error seen in the token body
  typedef enum logic [1:0] {
    SE_NONE    = 2'd0,
    SE_EARLY   = 2'd1,
    SE_UNKNOWN = 2'd2
  } scan_err_t;

  // status reported with the last character
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_OPEN  = 3'd1,
    ST_BAD_CLOSE = 3'd2,
    ST_EARLY_QT  = 3'd3,
    ST_UNK_ESC   = 3'd4
  } status_t;

  typedef struct packed {
    logic       known;
    logic [7:0] value;
  } esc_map_t;

  // one result word
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       done_res;
    status_t    status;
    logic [7:0] bad_escape;
  } result_t;

  function automatic esc_map_t map_escape(input logic [7:0] c);
    esc_map_t m;
    m.known = 1'b1;
    case (c)
      8'h5C: m.value = 8'h5C;
      8'h6E: m.value = 8'h0A;  // n
      8'h22: m.value = 8'h22;
      8'h27: m.value = 8'h27;
      8'h61: m.value = 8'h07;  // a
      8'h62: m.value = 8'h08;  // b
      8'h66: m.value = 8'h0C;  // f
      8'h72: m.value = 8'h0D;  // r
      8'h74: m.value = 8'h09;  // t
      8'h76: m.value = 8'h0B;  // v
      8'h3F: m.value = 8'h3F;
      8'h65: m.value = 8'h1B;  // e
      default: begin
        m.known = 1'b0;
        m.value = 8'h00;
      end
    endcase
    return m;
  endfunction

endpackage

[rtl/quoted_string_escape_decoder.sv]
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder
// Decodes a double-quoted string token with backslash escapes, one
// character per word, and reports a status on the token's last character.
// ----------------------------------------------------------------------------
// Data path: input reg, then result reg. Throughput: 1 word per cycle while
// out_tready does not stall the result reg; the scanner decodes one word per step.
// With a result stalled on out_tready one more word waits in the input reg,
// then in_tready drops.
// Reset (rst_n low, synchronous): both stages empty, scanner expects an
// opening quote with no errors recorded.
module quoted_string_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // is_last

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [10:8] status,
                                  // [18:11] bad_escape, [23:19] zero
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast   // done_res
);

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;

  // result stage
  logic              out_valid_r;
  qsed_pkg::result_t out_res_r;

  qsed_pkg::result_t dec_res;
  logic              s1_adv;
  logic              in_fire;

  // stage 1 moves forward when the result register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // scanner state advances only when the word in stage 1 is decoded
  qsed_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .ch      (s1_ch_r),
    .is_last (s1_last_r),
    .res     (dec_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_res_r.bad_escape, out_res_r.status,
                       out_res_r.out_byte};
  assign out_tuser  = out_res_r.byte_valid;
  assign out_tlast  = out_res_r.done_res;

endmodule

[rtl/qsed_decode.sv]
// ----------------------------------------------------------------------------
// qsed_decode
// Token scanner state and the per-character decode into one result word.
// ----------------------------------------------------------------------------
module qsed_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,     // consume ch/is_last this cycle
  input  logic [7:0]        ch,
  input  logic              is_last,
  output qsed_pkg::result_t res
);

  qsed_pkg::phase_t    phase_r, phase_nxt;
  logic                open_failed_r, open_failed_nxt;
  qsed_pkg::scan_err_t scan_err_r, scan_err_nxt;
  logic [7:0]          err_letter_r, err_letter_nxt;

  qsed_pkg::esc_map_t  esc;
  logic                err;

  always_comb begin
    esc = qsed_pkg::map_escape(ch);
    err = open_failed_r || (scan_err_r != qsed_pkg::SE_NONE);

    phase_nxt       = phase_r;
    open_failed_nxt = open_failed_r;
    scan_err_nxt    = scan_err_r;
    err_letter_nxt  = err_letter_r;

    res.byte_valid = 1'b0;
    res.out_byte   = 8'h00;
    res.done_res   = 1'b0;
    res.status     = qsed_pkg::ST_OK;
    res.bad_escape = 8'h00;

    if (is_last) begin
      res.done_res = 1'b1;
      if (open_failed_r || (phase_r == qsed_pkg::PH_OPEN && ch != qsed_pkg::QUOTE_CH)) begin
        res.status = qsed_pkg::ST_BAD_OPEN;
      end else if (ch != qsed_pkg::QUOTE_CH) begin
        res.status = qsed_pkg::ST_BAD_CLOSE;
      end else if (scan_err_r == qsed_pkg::SE_EARLY) begin
        res.status = qsed_pkg::ST_EARLY_QT;
      end else if (scan_err_r == qsed_pkg::SE_UNKNOWN) begin
        res.status     = qsed_pkg::ST_UNK_ESC;
        res.bad_escape = err_letter_r;
      end
      // backslash then final quote: quote counts as the escaped byte
      if (phase_r == qsed_pkg::PH_ESC && ch == qsed_pkg::QUOTE_CH &&
          res.status == qsed_pkg::ST_OK) begin
        res.byte_valid = 1'b1;
        res.out_byte   = qsed_pkg::QUOTE_CH;
      end
      phase_nxt       = qsed_pkg::PH_OPEN;
      open_failed_nxt = 1'b0;
      scan_err_nxt    = qsed_pkg::SE_NONE;
      err_letter_nxt  = 8'h00;
    end else begin
      case (phase_r)
        qsed_pkg::PH_OPEN: begin
          if (ch != qsed_pkg::QUOTE_CH) begin
            open_failed_nxt = 1'b1;
          end
          phase_nxt = qsed_pkg::PH_BODY;
        end
        qsed_pkg::PH_ESC: begin
          phase_nxt = qsed_pkg::PH_BODY;
          if (esc.known) begin
            if (!err) begin
              res.byte_valid = 1'b1;
              res.out_byte   = esc.value;
            end
          end else if (scan_err_r == qsed_pkg::SE_NONE) begin
            scan_err_nxt   = qsed_pkg::SE_UNKNOWN;
            err_letter_nxt = ch;
          end
        end
        default: begin  // body
          phase_nxt = qsed_pkg::PH_BODY;
          if (ch == qsed_pkg::QUOTE_CH) begin
            if (scan_err_r == qsed_pkg::SE_NONE) begin
              scan_err_nxt = qsed_pkg::SE_EARLY;
            end
          end else if (ch == qsed_pkg::BSLASH_CH) begin
            phase_nxt = qsed_pkg::PH_ESC;
          end else if (!err) begin
            res.byte_valid = 1'b1;
            res.out_byte   = ch;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= qsed_pkg::PH_OPEN;
      open_failed_r <= 1'b0;
      scan_err_r    <= qsed_pkg::SE_NONE;
      err_letter_r  <= 8'h00;
    end else if (step) begin
      phase_r       <= phase_nxt;
      open_failed_r <= open_failed_nxt;
      scan_err_r    <= scan_err_nxt;
      err_letter_r  <= err_letter_nxt;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quoted_string_escape_decoder. Tokens are sent one
// character per word: a short directed set for the corner cases, then
// well-formed tokens with random content, damaged tokens and raw noise.
// A local decoder predicts each result word; a checker compares them in order.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;

  // ways a token can be damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_OPEN,
    FLAW_EARLY_QUOTE,
    FLAW_UNKNOWN_ESC,
    FLAW_NO_CLOSE,
    FLAW_END_IN_ESC,
    FLAW_ESC_CLOSE
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] ch
  logic        in_tlast = 1'b0;    // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] out_byte, [10:8] status,
                                   // [18:11] bad_escape, [23:19] zero
  logic        out_tuser;          // [0] byte_valid
  logic        out_tlast;          // done_res

  quoted_string_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // escape letters the decoder knows
  logic [7:0] known_letters [12] = '{8'h5C, 8'h6E, 8'h22, 8'h27, 8'h61, 8'h62,
                                     8'h66, 8'h72, 8'h74, 8'h76, 8'h3F, 8'h65};

  // local copy of the scanner state
  qsed_pkg::phase_t    scan_ph = qsed_pkg::PH_OPEN;
  logic                bad_open = 1'b0;
  qsed_pkg::scan_err_t first_err = qsed_pkg::SE_NONE;
  logic [7:0]          err_letter = 8'h00;

  qsed_pkg::result_t pending_decodes[$];   // result words still owed by the dut
  int                mismatches = 0;
  int                items_sent = 0;
  int                cycles = 0;
  int                stall_left = 0;
  bit                no_gaps = 1'b0;       // back-to-back stretch on both sides
  qsed_pkg::result_t got_word;
  qsed_pkg::result_t want_word;

  // {known, byte} for the letter after a backslash
  function automatic logic [8:0] escape_lookup(input logic [7:0] c);
    case (c)
      8'h5C:   return {1'b1, 8'h5C};  // backslash
      8'h22:   return {1'b1, 8'h22};  // quote
      8'h27:   return {1'b1, 8'h27};  // apostrophe
      8'h3F:   return {1'b1, 8'h3F};  // question mark
      8'h61:   return {1'b1, 8'h07};  // a, bell
      8'h62:   return {1'b1, 8'h08};  // b, backspace
      8'h65:   return {1'b1, 8'h1B};  // e, escape
      8'h66:   return {1'b1, 8'h0C};  // f, form feed
      8'h6E:   return {1'b1, 8'h0A};  // n, line feed
      8'h72:   return {1'b1, 8'h0D};  // r, carriage return
      8'h74:   return {1'b1, 8'h09};  // t, tab
      8'h76:   return {1'b1, 8'h0B};  // v, vertical tab
      default: return 9'h000;
    endcase
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == qsed_pkg::QUOTE_CH || c == qsed_pkg::BSLASH_CH);
    return c;
  endfunction

  function automatic logic [7:0] unknown_letter();
    logic [7:0] c;
    logic [8:0] m;
    do begin
      c = 8'($urandom_range(1, 255));
      m = escape_lookup(c);
    end while (m[8]);
    return c;
  endfunction

  // Predicts the result word for one accepted character and steps the state.
  task automatic decode_char(input logic [7:0] c, input logic is_last);
    qsed_pkg::result_t r;
    logic [8:0]        esc;
    logic              had_err;
    r = '0;
    had_err = bad_open || (first_err != qsed_pkg::SE_NONE);
    esc = escape_lookup(c);
    if (is_last) begin
      r.done_res = 1'b1;
      // open failure outranks a bad close, which outranks scan errors
      if (bad_open || (scan_ph == qsed_pkg::PH_OPEN && c != qsed_pkg::QUOTE_CH)) begin
        r.status = qsed_pkg::ST_BAD_OPEN;
      end else if (c != qsed_pkg::QUOTE_CH) begin
        r.status = qsed_pkg::ST_BAD_CLOSE;
      end else if (first_err == qsed_pkg::SE_EARLY) begin
        r.status = qsed_pkg::ST_EARLY_QT;
      end else if (first_err == qsed_pkg::SE_UNKNOWN) begin
        r.status = qsed_pkg::ST_UNK_ESC;
        r.bad_escape = err_letter;
      end else begin
        r.status = qsed_pkg::ST_OK;
      end
      // lenient: backslash then final quote yields the quote byte
      if (scan_ph == qsed_pkg::PH_ESC && c == qsed_pkg::QUOTE_CH &&
          r.status == qsed_pkg::ST_OK) begin
        r.byte_valid = 1'b1;
        r.out_byte = qsed_pkg::QUOTE_CH;
      end
      scan_ph = qsed_pkg::PH_OPEN;
      bad_open = 1'b0;
      first_err = qsed_pkg::SE_NONE;
      err_letter = 8'h00;
    end else begin
      case (scan_ph)
        qsed_pkg::PH_OPEN: begin
          if (c != qsed_pkg::QUOTE_CH) bad_open = 1'b1;
          scan_ph = qsed_pkg::PH_BODY;
        end
        qsed_pkg::PH_ESC: begin
          scan_ph = qsed_pkg::PH_BODY;
          if (esc[8]) begin
            if (!had_err) begin
              r.byte_valid = 1'b1;
              r.out_byte = esc[7:0];
            end
          end else if (first_err == qsed_pkg::SE_NONE) begin
            first_err = qsed_pkg::SE_UNKNOWN;
            err_letter = c;
          end
        end
        default: begin
          if (c == qsed_pkg::QUOTE_CH) begin
            if (first_err == qsed_pkg::SE_NONE) first_err = qsed_pkg::SE_EARLY;
          end else if (c == qsed_pkg::BSLASH_CH) begin
            scan_ph = qsed_pkg::PH_ESC;
          end else if (!had_err) begin
            r.byte_valid = 1'b1;
            r.out_byte = c;
          end
        end
      endcase
    end
    pending_decodes.push_back(r);
  endtask

  // Sends one character word; entered and left at a falling edge.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = c;
    in_tlast = is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_char(c, is_last);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_seq(input logic [7:0] s[$]);
    for (int k = 0; k < s.size(); k++) send_char(s[k], k == s.size() - 1);
  endtask

  // Builds a token of the given number of body units with one optional flaw.
  task automatic send_token(input int units, input flaw_t flaw);
    logic [7:0] tok[$];
    int         flaw_at;
    flaw_at = $urandom_range(0, units);
    tok.push_back(flaw == FLAW_BAD_OPEN ? plain_char() : qsed_pkg::QUOTE_CH);
    for (int i = 0; i <= units; i++) begin
      if (i == flaw_at && flaw == FLAW_EARLY_QUOTE) begin
        tok.push_back(qsed_pkg::QUOTE_CH);
      end else if (i == flaw_at && flaw == FLAW_UNKNOWN_ESC) begin
        tok.push_back(qsed_pkg::BSLASH_CH);
        tok.push_back(unknown_letter());
      end
      if (i < units) begin
        if ($urandom_range(0, 9) < 3) begin
          tok.push_back(qsed_pkg::BSLASH_CH);
          tok.push_back(known_letters[4'($urandom_range(0, 11))]);
        end else begin
          tok.push_back(plain_char());
        end
      end
    end
    case (flaw)
      FLAW_NO_CLOSE:   tok.push_back(plain_char());
      FLAW_END_IN_ESC: tok.push_back(qsed_pkg::BSLASH_CH);
      FLAW_ESC_CLOSE: begin
        tok.push_back(qsed_pkg::BSLASH_CH);
        tok.push_back(qsed_pkg::QUOTE_CH);
      end
      default:         tok.push_back(qsed_pkg::QUOTE_CH);
    endcase
    send_seq(tok);
  endtask

  function automatic int pick_units();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 8);
    return $urandom_range(9, 30);
  endfunction

  // Holds the sender until every predicted word has come back.
  task automatic wait_drained();
    while (pending_decodes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_seq('{8'h22});                                   // lone quote
    send_seq('{8'hFF});                                   // bad open, single char
    send_seq('{8'h01, 8'h22, 8'h22});                     // bad open beats early quote
    send_seq('{8'h22, 8'h01, 8'hFF, 8'h5C, 8'h5C, 8'h5C, 8'h6E, 8'h22});
    send_seq('{8'h22, 8'h22, 8'h61, 8'h22});              // early quote, output muted
    send_seq('{8'h22, 8'h5C, 8'h7A, 8'h5C, 8'h01, 8'h22}); // first unknown kept
    send_seq('{8'h22, 8'h61});                            // bad close
    send_seq('{8'h22, 8'h5C});                            // ends inside escape
    send_seq('{8'h22, 8'h5C, 8'h22});                     // escaped final quote
  endtask

  task automatic test_well_formed(input int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(0, 9) < 8) send_token(pick_units(), FLAW_NONE);
      else send_token(pick_units(), flaw_t'($urandom_range(FLAW_BAD_OPEN, FLAW_ESC_CLOSE)));
    end
  endtask

  task automatic test_back_to_back(input int n);
    no_gaps = 1'b1;
    test_well_formed(n);
    no_gaps = 1'b0;
  endtask

  task automatic test_broken(input int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop)
      send_token(pick_units(), flaw_t'($urandom_range(FLAW_BAD_OPEN, FLAW_ESC_CLOSE)));
  endtask

  task automatic test_noise(input int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop)
      send_char(8'($urandom_range(1, 255)), $urandom_range(0, 5) == 0);
    send_char(qsed_pkg::QUOTE_CH, 1'b1);  // close whatever token the noise left open
  endtask

  // Result side: random stalls, mostly short, with a few long ones.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
      out_tready = 1'b0;
      stall_left = pick_gap();
    end else begin
      out_tready = 1'b1;
    end
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.byte_valid = out_tuser;
      got_word.out_byte = out_tdata[7:0];
      got_word.done_res = out_tlast;
      got_word.status = qsed_pkg::status_t'(out_tdata[10:8]);
      got_word.bad_escape = out_tdata[18:11];
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: result word with none expected:",
                    " v=%0b byte=%02h done=%0b st=%0d esc=%02h"},
                   $realtime, got_word.byte_valid, got_word.out_byte, got_word.done_res,
                   got_word.status, got_word.bad_escape);
      end else begin
        want_word = pending_decodes.pop_front();
        if (got_word !== want_word || out_tdata[23:19] !== 5'd0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: mismatch exp v=%0b byte=%02h done=%0b st=%0d esc=%02h",
                      " | got v=%0b byte=%02h done=%0b st=%0d esc=%02h pad=%02h"},
                     $realtime, want_word.byte_valid, want_word.out_byte,
                     want_word.done_res, want_word.status, want_word.bad_escape,
                     got_word.byte_valid, got_word.out_byte, got_word.done_res,
                     got_word.status, got_word.bad_escape, out_tdata[23:19]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("quoted_string_escape_decoder test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    wait_drained();
    test_well_formed(600);
    wait_drained();
    test_back_to_back(150);
    test_broken(300);
    wait_drained();
    test_noise(170);
    wait_drained();
    repeat (20) @(posedge clk);  // room for any stray word after the last one
    if (mismatches == 0 && pending_decodes.size() == 0)
      $display("quoted_string_escape_decoder test passed");
    else
      $display("quoted_string_escape_decoder test failed");
    $finish;
  end

endmodule
